### src/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg: shared definitions for the grasp signature classifier
// Class codes, thresholds and the payload records carried between stages.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int unsigned FINGERS = 4;

    localparam logic [9:0] CONTACT_MAX  = 10'd1000;
    localparam logic [9:0] THIN_MIN     = 10'd800;
    localparam logic [9:0] LARGE_MAX    = 10'd250;
    localparam logic [9:0] MID_SPLIT    = 10'd525;
    localparam logic [9:0] SPREAD_FLAT  = 10'd250;
    localparam logic [9:0] DIST_CAP     = 10'd200;
    localparam logic [9:0] TIGHT_SPREAD = 10'd80;
    localparam logic [6:0] BASE_CONF    = 7'd40;
    localparam logic [6:0] CONF_THUMB   = 7'd45;
    localparam logic [6:0] CONF_EMPTY_T = 7'd90;
    localparam logic [6:0] CONF_EMPTY   = 7'd60;
    localparam logic [6:0] CONF_CAP     = 7'd100;

    // reciprocal of 3 in Q13, exact for sums below 8190
    localparam logic [11:0] RECIP3      = 12'd2731;
    // reciprocal of 10 in Q11, exact for values up to 255
    localparam logic [7:0]  RECIP10     = 8'd205;

    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_THIN  = 3'd1;
    localparam logic [2:0] CLS_CYL   = 3'd2;
    localparam logic [2:0] CLS_FLAT  = 3'd3;
    localparam logic [2:0] CLS_LARGE = 3'd4;
    localparam logic [2:0] CLS_UNDEF = 3'd5;

    // items common to the stage B, C and D records
    typedef struct packed {
        logic [2:0] voters;
        logic [2:0] hits;
        logic       thumb_sensed;
        logic       thumb_touch;
    } gsc_tag_t;

    typedef struct packed {
        logic [3:0][9:0] pos;
        logic [3:0]      hit;
        logic [3:0]      sense;
        logic            thumb_sensed;
        logic            thumb_touch;
    } gsc_sa_t;

    typedef struct packed {
        gsc_tag_t    tag;
        logic [11:0] sum;
        logic [9:0]  lo;
        logic [9:0]  hi;
    } gsc_sb_t;

    typedef struct packed {
        gsc_tag_t   tag;
        logic [9:0] mean;
        logic [9:0] spread;
    } gsc_sc_t;

    typedef struct packed {
        gsc_tag_t   tag;
        logic [2:0] cls;
        logic [6:0] conf;
    } gsc_sd_t;

endpackage

### src/grasp_signature_classifier_unit.sv
// ----------------------------------------------------------------------------
// grasp_signature_classifier_unit: grasp class and confidence from contacts
// Five-stage pipeline: saturate, reduce, mean, classify, scale and cap.
// ----------------------------------------------------------------------------
// One contact signature enters per transfer on the s_ side and exactly one
// result leaves per transfer on the m_ side, in order. The pipeline takes a
// new signature every cycle while s_tready is high; m_tvalid rises once the
// transfer has passed the stage registers A to E. Stages: saturate positions
// and form the touching mask, reduce to sum/min/max and finger counts, divide
// the sum by the touching count (a reciprocal multiply for three fingers),
// classify and score, then scale by sensor coverage and cap at 100. A stall
// on m_tready holds each full stage with no empty stage after it; the others
// keep filling, so s_tready drops only once the whole pipeline is full.
module grasp_signature_classifier_unit
    import gsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // sensor_mask[4:0], touched_mask[9:5], contact_little[19:10],
    // contact_ring[29:20], contact_middle[39:30], contact_index[49:40]
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // object_class[2:0], confidence[9:3]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    logic     va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic     adv_a, adv_b, adv_c, adv_d, adv_e;
    gsc_sa_t  sa_reg, sa_next;
    gsc_sb_t  sb_reg, sb_next;
    gsc_sc_t  sc_reg, sc_next;
    gsc_sd_t  sd_reg, sd_next;
    logic [2:0] cls_reg, cls_next;
    logic [6:0] conf_reg, conf_next;

    // A stage advances when it is empty or the one after it advances.
    assign adv_e    = !ve_reg || m_tready;
    assign adv_d    = !vd_reg || adv_e;
    assign adv_c    = !vc_reg || adv_d;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !va_reg || adv_b;
    assign s_tready = adv_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (adv_a) va_reg <= s_tvalid;
            if (adv_b) vb_reg <= va_reg;
            if (adv_c) vc_reg <= vb_reg;
            if (adv_d) vd_reg <= vc_reg;
            if (adv_e) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) sa_reg <= sa_next;
        if (adv_b) sb_reg <= sb_next;
        if (adv_c) sc_reg <= sc_next;
        if (adv_d) sd_reg <= sd_next;
        if (adv_e) begin
            cls_reg  <= cls_next;
            conf_reg <= conf_next;
        end
    end

    // Stage A: saturate positions, form the touching-with-sensor mask.
    always_comb begin
        logic [9:0] raw;
        sa_next.sense        = s_tdata[3:0];
        sa_next.hit          = s_tdata[3:0] & s_tdata[8:5];
        sa_next.thumb_sensed = s_tdata[4];
        sa_next.thumb_touch  = s_tdata[9];
        for (int i = 0; i < FINGERS; i++) begin
            raw = s_tdata[10 + 10*i +: 10];
            sa_next.pos[i] = (raw > CONTACT_MAX) ? CONTACT_MAX : raw;
        end
    end

    // Stage B: sum, minimum and maximum over the touching fingers; counts.
    always_comb begin
        logic [11:0] sum;
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [2:0]  nv;
        logic [2:0]  nh;
        sum = 12'd0;
        lo  = CONTACT_MAX;
        hi  = 10'd0;
        nv  = 3'd0;
        nh  = 3'd0;
        for (int i = 0; i < FINGERS; i++) begin
            nv = nv + {2'b00, sa_reg.sense[i]};
            nh = nh + {2'b00, sa_reg.hit[i]};
            if (sa_reg.hit[i]) begin
                sum = sum + {2'b00, sa_reg.pos[i]};
                if (sa_reg.pos[i] < lo) lo = sa_reg.pos[i];
                if (sa_reg.pos[i] > hi) hi = sa_reg.pos[i];
            end
        end
        sb_next.sum              = sum;
        sb_next.lo               = lo;
        sb_next.hi               = hi;
        sb_next.tag.voters       = nv;
        sb_next.tag.hits         = nh;
        sb_next.tag.thumb_sensed = sa_reg.thumb_sensed;
        sb_next.tag.thumb_touch  = sa_reg.thumb_touch;
    end

    // Stage C: mean by a shift or a reciprocal multiply; spread.
    always_comb begin
        logic [23:0] prod3;
        logic [11:0] mean_w;
        prod3 = sb_reg.sum * RECIP3;
        case (sb_reg.tag.hits)
            3'd2:    mean_w = {1'b0, sb_reg.sum[11:1]};
            3'd3:    mean_w = {1'b0, prod3[23:13]};
            3'd4:    mean_w = {2'b00, sb_reg.sum[11:2]};
            default: mean_w = sb_reg.sum;
        endcase
        sc_next.mean   = mean_w[9:0];
        sc_next.spread = sb_reg.hi - sb_reg.lo;
        sc_next.tag    = sb_reg.tag;
    end

    // Stage D: class, distance from the boundary and raw confidence.
    always_comb begin
        logic [9:0]  mean;
        logic [9:0]  margin;
        logic [15:0] prod10;
        logic [6:0]  bonus;
        logic [6:0]  base;
        mean = sc_reg.mean;
        if (mean >= THIN_MIN)                 sd_next.cls = CLS_THIN;
        else if (mean <= LARGE_MAX)           sd_next.cls = CLS_LARGE;
        else if (sc_reg.spread > SPREAD_FLAT) sd_next.cls = CLS_FLAT;
        else                                  sd_next.cls = CLS_CYL;

        if (mean > THIN_MIN)       margin = mean - THIN_MIN;
        else if (mean < LARGE_MAX) margin = LARGE_MAX - mean;
        else if (mean < MID_SPLIT) margin = mean - LARGE_MAX;
        else                       margin = THIN_MIN - mean;

        prod10 = margin[7:0] * RECIP10;
        bonus  = (margin > DIST_CAP) ? 7'd20 : {2'b00, prod10[15:11]};
        base   = BASE_CONF + 7'(sc_reg.tag.hits) * 7'd10;
        sd_next.conf = base + bonus;
        if (sd_next.cls == CLS_CYL && sc_reg.spread < TIGHT_SPREAD) begin
            sd_next.conf = sd_next.conf + 7'd10;
        end
        sd_next.tag = sc_reg.tag;
    end

    // Stage E: scale by coverage, cap, and resolve the no-contact cases.
    always_comb begin
        logic [9:0] scaled;
        logic [7:0] quarter;
        scaled  = sd_reg.conf * sd_reg.tag.voters;
        quarter = scaled[9:2];
        if (sd_reg.tag.voters == 3'd0) begin
            cls_next  = CLS_UNDEF;
            conf_next = 7'd0;
        end else if (sd_reg.tag.hits == 3'd0) begin
            if (sd_reg.tag.thumb_sensed && sd_reg.tag.thumb_touch) begin
                cls_next  = CLS_UNDEF;
                conf_next = CONF_THUMB;
            end else begin
                cls_next  = CLS_NONE;
                conf_next = sd_reg.tag.thumb_sensed ? CONF_EMPTY_T : CONF_EMPTY;
            end
        end else begin
            cls_next  = sd_reg.cls;
            conf_next = (quarter > {1'b0, CONF_CAP}) ? CONF_CAP : quarter[6:0];
        end
    end

    assign m_tvalid = ve_reg;
    assign m_tdata  = {6'd0, conf_reg, cls_reg};

    // An empty output stage lets the whole pipeline move.
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !ve_reg |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_conf_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[9:3] <= CONF_CAP))
        else $error("confidence above cap");

    a_class_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= CLS_UNDEF))
        else $error("illegal class code");

    a_none_conf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == CLS_NONE) |->
            (m_tdata[9:3] == CONF_EMPTY_T || m_tdata[9:3] == CONF_EMPTY))
        else $error("empty grasp with unexpected confidence");

endmodule
